// ----- hw/rtl/bitfield_pixel_to_bgra8_unit_defines.svh -----
// assertion macros shared by the bitfield pixel unpacker rtl
`ifndef BITFIELD_PIXEL_TO_BGRA8_UNIT_DEFINES_SVH
`define BITFIELD_PIXEL_TO_BGRA8_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// clocked assertion, off while reset is high
`define BFP2B_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// clocked assertion, also checked during reset
`define BFP2B_ASSERT_NR(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define BFP2B_ASSERT(lbl, clk, rst, prop, msg)
`define BFP2B_ASSERT_NR(lbl, clk, prop, msg)
`endif

`endif

// ----- hw/rtl/bfp2b_pkg.sv -----
// shared types and constants of the bitfield pixel unpacker
`default_nettype none

package bfp2b_pkg;

   localparam int unsigned PIXEL_W     = 32;
   localparam int unsigned CHAN_W      = 8;
   localparam int unsigned DIVIDEND_W  = PIXEL_W + CHAN_W;
   localparam int unsigned DIV_STEPS   = CHAN_W;
   localparam int unsigned STEP_CNT_W  = $clog2(DIV_STEPS);
   localparam int unsigned SHIFTED_W   = PIXEL_W + DIV_STEPS - 1;
   localparam int unsigned CSR_INDEX_W = 3;

   localparam logic [PIXEL_W-1:0] RED_MASK_RST   = 32'h00FF_0000;
   localparam logic [PIXEL_W-1:0] GREEN_MASK_RST = 32'h0000_FF00;
   localparam logic [PIXEL_W-1:0] BLUE_MASK_RST  = 32'h0000_00FF;
   localparam logic [PIXEL_W-1:0] ALPHA_MASK_RST = 32'hFF00_0000;
   localparam logic               WIDE_RST       = 1'b1;
   localparam logic               USE_BF_RST     = 1'b0;
   localparam logic [CHAN_W-1:0]  OPAQUE_ALPHA   = 8'hFF;

   // register indexes of the configuration port
   localparam logic [CSR_INDEX_W-1:0] CSR_RED_MASK   = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_GREEN_MASK = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_BLUE_MASK  = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_ALPHA_MASK = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_WIDE       = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_USE_BF     = 3'd5;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LAUNCH,
      ST_WAIT,
      ST_FINISH
   } state_type;

   typedef enum logic [1:0] {
      CH_BLUE,
      CH_GREEN,
      CH_RED,
      CH_ALPHA
   } chan_type;

   typedef struct packed {
      logic start;
   } div_ctrl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage

`default_nettype wire

// ----- hw/rtl/bitfield_pixel_to_bgra8_unit.sv -----
// top level of the bitfield pixel to bgra8 unpacker
// usage:
//   req_ channel: one source pixel per request, pixel word in req_tdata,
//   req_tlast marks the last pixel of the image
//   rsp_ channel: one bgra8 result per request, rsp_tlast copies req_tlast,
//   rsp_tuser raises on the last pixel of a 32-bit image whose alpha was
//   zero throughout, so downstream forces every alpha of that image to 255
//   csr_ channel: register writes, always ready; write only with no request in flight
// timing:
//   the four channels run one after another through a single divider that
//   makes one quotient bit per cycle; each channel passes through launch,
//   run isolation, 8 divide steps and capture
//   requests are taken one at a time: a new one is accepted only once the
//   previous result has been loaded into the output register
// stalls:
//   the result sits in an output register; a new request is accepted while
//   it waits, and only the final load waits for rsp_tready
// reset:
//   synchronous, active high; registers return to the default masks and
//   32-bit mode, the alpha history clears and both channels go idle
`default_nettype none

`include "bitfield_pixel_to_bgra8_unit_defines.svh"

module bitfield_pixel_to_bgra8_unit
   import bfp2b_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,

   // request channel
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   input  wire logic [PIXEL_W-1:0]     req_tdata,   // [31:0] pixel_word
   input  wire logic                   req_tlast,   // last_pixel

   // result channel
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   output logic [4*CHAN_W-1:0]         rsp_tdata,   // [7:0] blue, [15:8] green,
                                                    // [23:16] red, [31:24] alpha
   output logic                        rsp_tlast,   // end_of_image
   output logic                        rsp_tuser,   // [0] force_opaque

   // configuration write channel
   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [PIXEL_W-1:0]     csr_data
);

   // configuration registers
   logic [PIXEL_W-1:0] red_mask_ff,   red_mask_in;
   logic [PIXEL_W-1:0] green_mask_ff, green_mask_in;
   logic [PIXEL_W-1:0] blue_mask_ff,  blue_mask_in;
   logic [PIXEL_W-1:0] alpha_mask_ff, alpha_mask_in;
   logic               wide_ff,       wide_in;
   logic               use_bf_ff,     use_bf_in;

   // sequencer and request hold
   state_type          state_ff,      state_in;
   chan_type           chan_ff,       chan_in;
   logic [PIXEL_W-1:0] pix_ff,        pix_in;
   logic               last_ff,       last_in;
   logic [CHAN_W-1:0]  chan_q_ff [4];
   logic [CHAN_W-1:0]  chan_q_in [4];
   logic               alpha_seen_ff, alpha_seen_in;

   // output register
   logic                rsp_valid_ff, rsp_valid_in;
   logic [4*CHAN_W-1:0] rsp_data_ff,  rsp_data_in;
   logic                rsp_last_ff,  rsp_last_in;
   logic                rsp_force_ff, rsp_force_in;

   // divider hookup
   div_ctrl_type       div_ctrl;
   div_status_type     div_status;
   logic [PIXEL_W-1:0] div_value;
   logic [PIXEL_W-1:0] div_mask;
   logic [CHAN_W-1:0]  div_quotient;

   // final assembly
   logic [CHAN_W-1:0]  blue_res, green_res, red_res, alpha_res;
   logic               seen_now;
   logic               force_now;
   logic               load_rsp;
   logic               csr_write;

   assign csr_ready  = 1'b1;
   assign csr_write  = csr_valid && csr_ready;
   assign req_tready = (state_ff == ST_IDLE);

   // register writes, unknown indexes dropped
   always_comb begin
      red_mask_in   = red_mask_ff;
      green_mask_in = green_mask_ff;
      blue_mask_in  = blue_mask_ff;
      alpha_mask_in = alpha_mask_ff;
      wide_in       = wide_ff;
      use_bf_in     = use_bf_ff;
      if (csr_write) begin
         case (csr_index)
            CSR_RED_MASK:   red_mask_in   = csr_data;
            CSR_GREEN_MASK: green_mask_in = csr_data;
            CSR_BLUE_MASK:  blue_mask_in  = csr_data;
            CSR_ALPHA_MASK: alpha_mask_in = csr_data;
            CSR_WIDE:       wide_in       = csr_data[0];
            CSR_USE_BF:     use_bf_in     = csr_data[0];
            default: ;
         endcase
      end
   end

   // 24-bit pixels ignore the top byte
   assign div_value = wide_ff ? pix_ff : {CHAN_W'(0), pix_ff[PIXEL_W-CHAN_W-1:0]};

   always_comb begin
      case (chan_ff)
         CH_BLUE:  div_mask = blue_mask_ff;
         CH_GREEN: div_mask = green_mask_ff;
         CH_RED:   div_mask = red_mask_ff;
         CH_ALPHA: div_mask = alpha_mask_ff;
         default:  div_mask = '0;
      endcase
   end

   bfp2b_div u_div (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (div_ctrl),
      .value_in (div_value),
      .mask_in  (div_mask),
      .status   (div_status),
      .quotient (div_quotient)
   );

   // result fields from the scaled channels or from a plain byte copy
   always_comb begin
      if (wide_ff || use_bf_ff) begin
         blue_res  = chan_q_ff[CH_BLUE];
         green_res = chan_q_ff[CH_GREEN];
         red_res   = chan_q_ff[CH_RED];
      end else begin
         blue_res  = pix_ff[CHAN_W-1:0];
         green_res = pix_ff[2*CHAN_W-1:CHAN_W];
         red_res   = pix_ff[3*CHAN_W-1:2*CHAN_W];
      end
      if (!wide_ff) begin
         alpha_res = OPAQUE_ALPHA;
      end else if (alpha_mask_ff == '0) begin
         alpha_res = pix_ff[PIXEL_W-1:PIXEL_W-CHAN_W];
      end else begin
         alpha_res = chan_q_ff[CH_ALPHA];
      end
   end

   // alpha history includes this pixel before the last-pixel decision
   assign seen_now  = alpha_seen_ff || (wide_ff && (alpha_res != '0));
   assign force_now = last_ff && wide_ff && !seen_now;
   assign load_rsp  = (state_ff == ST_FINISH) && (!rsp_valid_ff || rsp_tready);

   // sequencer: blue, green, red, alpha through the divider, then load result
   always_comb begin
      state_in       = state_ff;
      chan_in        = chan_ff;
      pix_in         = pix_ff;
      last_in        = last_ff;
      chan_q_in      = chan_q_ff;
      div_ctrl.start = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               pix_in   = req_tdata;
               last_in  = req_tlast;
               chan_in  = CH_BLUE;
               state_in = ST_LAUNCH;
            end
         end
         ST_LAUNCH: begin
            div_ctrl.start = 1'b1;
            state_in       = ST_WAIT;
         end
         ST_WAIT: begin
            if (div_status.done) begin
               chan_q_in[chan_ff] = div_quotient;
               if (chan_ff == CH_ALPHA) begin
                  state_in = ST_FINISH;
               end else begin
                  chan_in  = chan_type'(chan_ff + 2'd1);
                  state_in = ST_LAUNCH;
               end
            end
         end
         ST_FINISH: begin
            if (load_rsp) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // output register and alpha history
   always_comb begin
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_data_in   = rsp_data_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_force_in  = rsp_force_ff;
      alpha_seen_in = alpha_seen_ff;
      if (load_rsp) begin
         rsp_valid_in  = 1'b1;
         rsp_data_in   = {alpha_res, red_res, green_res, blue_res};
         rsp_last_in   = last_ff;
         rsp_force_in  = force_now;
         alpha_seen_in = seen_now && !last_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         red_mask_ff   <= RED_MASK_RST;
         green_mask_ff <= GREEN_MASK_RST;
         blue_mask_ff  <= BLUE_MASK_RST;
         alpha_mask_ff <= ALPHA_MASK_RST;
         wide_ff       <= WIDE_RST;
         use_bf_ff     <= USE_BF_RST;
         state_ff      <= ST_IDLE;
         chan_ff       <= CH_BLUE;
         alpha_seen_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         red_mask_ff   <= red_mask_in;
         green_mask_ff <= green_mask_in;
         blue_mask_ff  <= blue_mask_in;
         alpha_mask_ff <= alpha_mask_in;
         wide_ff       <= wide_in;
         use_bf_ff     <= use_bf_in;
         state_ff      <= state_in;
         chan_ff       <= chan_in;
         alpha_seen_ff <= alpha_seen_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pix_ff       <= pix_in;
      last_ff      <= last_in;
      chan_q_ff    <= chan_q_in;
      rsp_data_ff  <= rsp_data_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_force_ff <= rsp_force_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_force_ff;

   // a request always starts the divider on blue
   `BFP2B_ASSERT(a_accept_launch, clock, reset, (req_tvalid && req_tready) |=> (state_ff == ST_LAUNCH && chan_ff == CH_BLUE), "request accept did not launch blue")

   // divider only finishes while the sequencer waits for it
   `BFP2B_ASSERT(a_done_in_wait, clock, reset, div_status.done |-> (state_ff == ST_WAIT), "divider finished outside wait")

   // the divider is free whenever a channel is launched
   `BFP2B_ASSERT(a_launch_free, clock, reset, (state_ff == ST_LAUNCH) |-> !div_status.busy, "launch while divider busy")

   // a new result only appears out of the finish step
   `BFP2B_ASSERT(a_rsp_from_finish, clock, reset, $rose(rsp_tvalid) |-> ($past(state_ff) == ST_FINISH), "result valid without finish")

   // force_opaque is only raised on the last pixel
   `BFP2B_ASSERT_NR(a_force_on_last, clock, (rsp_tvalid && rsp_tuser) |-> rsp_tlast, "force_opaque away from last pixel")

endmodule

`default_nettype wire

// ----- hw/rtl/bfp2b_div.sv -----
// shared field scaler: isolates the lowest mask run and divides, one quotient bit a cycle
`default_nettype none

module bfp2b_div
   import bfp2b_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire div_ctrl_type         ctrl,
   input  wire logic [PIXEL_W-1:0]   value_in,
   input  wire logic [PIXEL_W-1:0]   mask_in,
   output div_status_type            status,
   output logic      [CHAN_W-1:0]    quotient
);

   logic [PIXEL_W-1:0]    low_bit;
   logic [PIXEL_W-1:0]    run_mask;

   logic [PIXEL_W-1:0]    run_ff,    run_in;
   logic [PIXEL_W-1:0]    masked_ff, masked_in;
   logic [DIVIDEND_W-1:0] rem_ff,    rem_in;
   logic [SHIFTED_W-1:0]  dsh_ff,    dsh_in;
   logic [CHAN_W-1:0]     quo_ff,    quo_in;
   logic [STEP_CNT_W-1:0] cnt_ff,    cnt_in;
   logic                  prep_ff,   prep_in;
   logic                  busy_ff,   busy_in;
   logic                  done_ff,   done_in;

   logic [DIVIDEND_W-1:0] masked_ext;
   logic [DIVIDEND_W-1:0] dividend;
   logic [DIVIDEND_W-1:0] dsh_ext;
   logic [DIVIDEND_W-1:0] diff;
   logic                  take;

   // lowest contiguous run of ones in the mask
   assign low_bit  = mask_in & (~mask_in + PIXEL_W'(1));
   assign run_mask = mask_in & ~(mask_in + low_bit);

   // field*255 + max/2, both kept at the run's position so the shift cancels
   assign masked_ext = {CHAN_W'(0), masked_ff};
   assign dividend   = (masked_ext << CHAN_W) - masked_ext
                     + {CHAN_W'(0), run_ff & (run_ff >> 1)};

   assign dsh_ext = {1'b0, dsh_ff};
   assign diff    = rem_ff - dsh_ext;
   assign take    = rem_ff >= dsh_ext;

   always_comb begin
      run_in    = run_ff;
      masked_in = masked_ff;
      rem_in    = rem_ff;
      dsh_in    = dsh_ff;
      quo_in    = quo_ff;
      cnt_in    = cnt_ff;
      prep_in   = prep_ff;
      busy_in   = busy_ff;
      done_in   = 1'b0;
      if (ctrl.start) begin
         run_in    = run_mask;
         masked_in = value_in & run_mask;
         prep_in   = 1'b1;
         busy_in   = 1'b1;
      end else if (prep_ff) begin
         rem_in  = dividend;
         dsh_in  = {run_ff, (DIV_STEPS-1)'(0)};
         quo_in  = '0;
         cnt_in  = '0;
         prep_in = 1'b0;
      end else if (busy_ff) begin
         if (take) begin
            rem_in = diff;
         end
         quo_in = {quo_ff[CHAN_W-2:0], take};
         dsh_in = dsh_ff >> 1;
         cnt_in = cnt_ff + STEP_CNT_W'(1);
         if (cnt_ff == STEP_CNT_W'(DIV_STEPS-1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prep_ff <= 1'b0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         prep_ff <= prep_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      run_ff    <= run_in;
      masked_ff <= masked_in;
      rem_ff    <= rem_in;
      dsh_ff    <= dsh_in;
      quo_ff    <= quo_in;
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   // empty mask scales to zero
   assign quotient = (run_ff == '0) ? '0 : quo_ff;

endmodule

`default_nettype wire

// ----- bench/bgra8_result_checker.sv -----
// channel monitor that predicts and checks every bgra8 result of the pixel unpacker
`timescale 1ns / 1ps

module bgra8_result_checker
   import bfp2b_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   input  logic                   req_tready,
   input  logic [PIXEL_W-1:0]     req_tdata,
   input  logic                   req_tlast,
   input  logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   input  logic [4*CHAN_W-1:0]    rsp_tdata,
   input  logic                   rsp_tlast,
   input  logic                   rsp_tuser,
   input  logic                   csr_valid,
   input  logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [PIXEL_W-1:0]     csr_data,
   output int unsigned            error_count,
   output int unsigned            outstanding
);

   typedef struct packed {
      logic [CHAN_W-1:0] blue;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] red;
      logic [CHAN_W-1:0] alpha;
      logic              end_of_image;
      logic              force_opaque;
   } bgra_pixel_type;

   logic [PIXEL_W-1:0] red_sel;
   logic [PIXEL_W-1:0] green_sel;
   logic [PIXEL_W-1:0] blue_sel;
   logic [PIXEL_W-1:0] alpha_sel;
   logic               wide_mode;
   logic               bitfields_on;
   logic               alpha_history;
   bgra_pixel_type     pending_bgra [$];

   initial begin
      error_count = 0;
      outstanding = 0;
   end

   task automatic report_error(input string msg);
      $display("%0t ns: mismatch: %s", $time, msg);
      error_count++;
   endtask

   task automatic check_field(input string name, input logic [CHAN_W-1:0] got,
                              input logic [CHAN_W-1:0] want);
      if (got !== want) begin
         report_error($sformatf("%s got %0h expected %0h", name, got, want));
      end
   endtask

   // lowest contiguous run of the mask, scaled to eight bits with rounding to nearest
   function automatic logic [CHAN_W-1:0] scale_channel(input logic [PIXEL_W-1:0] word,
                                                       input logic [PIXEL_W-1:0] mask);
      int unsigned lsb;
      int unsigned run;
      logic [63:0] full_scale;
      logic [63:0] field;
      lsb = 0;
      run = 0;
      if (mask == '0) begin
         return '0;
      end
      while (lsb < PIXEL_W - 1 && !mask[lsb]) lsb++;
      while (lsb + run < PIXEL_W && mask[lsb + run]) run++;
      full_scale = (64'd1 << run) - 64'd1;
      field = (64'(word) >> lsb) & full_scale;
      return CHAN_W'((field * 64'd255 + full_scale / 64'd2) / full_scale);
   endfunction

   function automatic bgra_pixel_type predict_bgra(input logic [PIXEL_W-1:0] word,
                                                   input logic last);
      bgra_pixel_type px;
      logic [PIXEL_W-1:0] low3;
      px = '0;
      low3 = {8'h00, word[23:0]};
      if (wide_mode) begin
         px.blue  = scale_channel(word, blue_sel);
         px.green = scale_channel(word, green_sel);
         px.red   = scale_channel(word, red_sel);
         px.alpha = (alpha_sel == '0) ? word[31:24] : scale_channel(word, alpha_sel);
         if (px.alpha != '0) begin
            alpha_history = 1'b1;
         end
      end else begin
         if (bitfields_on) begin
            px.blue  = scale_channel(low3, blue_sel);
            px.green = scale_channel(low3, green_sel);
            px.red   = scale_channel(low3, red_sel);
         end else begin
            px.blue  = word[7:0];
            px.green = word[15:8];
            px.red   = word[23:16];
         end
         px.alpha = OPAQUE_ALPHA;
      end
      px.end_of_image = last;
      if (last) begin
         px.force_opaque = wide_mode && !alpha_history;
         alpha_history = 1'b0;
      end
      return px;
   endfunction

   always @(posedge clock) begin
      bgra_pixel_type want;
      if (reset) begin
         red_sel       = RED_MASK_RST;
         green_sel     = GREEN_MASK_RST;
         blue_sel      = BLUE_MASK_RST;
         alpha_sel     = ALPHA_MASK_RST;
         wide_mode     = WIDE_RST;
         bitfields_on  = USE_BF_RST;
         alpha_history = 1'b0;
         pending_bgra.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_RED_MASK:   red_sel = csr_data;
               CSR_GREEN_MASK: green_sel = csr_data;
               CSR_BLUE_MASK:  blue_sel = csr_data;
               CSR_ALPHA_MASK: alpha_sel = csr_data;
               CSR_WIDE:       wide_mode = csr_data[0];
               CSR_USE_BF:     bitfields_on = csr_data[0];
               default: ;
            endcase
         end
         if (rsp_tvalid && rsp_tready) begin
            if (pending_bgra.size() == 0) begin
               report_error("result with no request outstanding");
            end else begin
               want = pending_bgra.pop_front();
               check_field("blue", rsp_tdata[CHAN_W-1:0], want.blue);
               check_field("green", rsp_tdata[2*CHAN_W-1:CHAN_W], want.green);
               check_field("red", rsp_tdata[3*CHAN_W-1:2*CHAN_W], want.red);
               check_field("alpha", rsp_tdata[4*CHAN_W-1:3*CHAN_W], want.alpha);
               check_field("end_of_image", CHAN_W'(rsp_tlast), CHAN_W'(want.end_of_image));
               check_field("force_opaque", CHAN_W'(rsp_tuser), CHAN_W'(want.force_opaque));
            end
         end
         if (req_tvalid && req_tready) begin
            pending_bgra.push_back(predict_bgra(req_tdata, req_tlast));
         end
      end
      outstanding = pending_bgra.size();
   end

endmodule

// ----- bench/bitfield_pixel_to_bgra8_unit_tb.sv -----
// stimulus and verdict for the bitfield pixel to bgra8 unpacker
`timescale 1ns / 1ps

module bitfield_pixel_to_bgra8_unit_tb;
   import bfp2b_pkg::*;

   localparam int unsigned CLK_HALF         = 4;
   localparam int unsigned RESET_CYCLES     = 11;
   // slack after draining, before the next register write or request
   localparam int unsigned SETTLE_CYCLES    = 8;
   localparam int unsigned TAIL_CYCLES      = 60;
   localparam int unsigned LONG_HOLD_CYCLES = 400;
   localparam int unsigned RANDOM_PHASES    = 9;
   localparam int unsigned PHASE_PIXELS     = 136;
   localparam int unsigned HOLD_PHASE       = 3;
   localparam int unsigned PAUSE_PHASE      = 5;
   // register indexes beyond the map, which the block must ignore
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_6 = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_7 = 3'd7;

   typedef enum int unsigned {
      MS_DEFAULT,
      MS_565,
      MS_555,
      MS_2101010,
      MS_RUNS,
      MS_RANDOM,
      MS_EMPTY,
      MS_FULL
   } mask_style_type;

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [PIXEL_W-1:0]     req_tdata;     // [31:0] pixel_word
   logic                   req_tlast;     // last_pixel
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [4*CHAN_W-1:0]    rsp_tdata;     // [7:0] blue, [15:8] green, [23:16] red, [31:24] alpha
   logic                   rsp_tlast;     // end_of_image
   logic                   rsp_tuser;     // [0] force_opaque
   logic                   csr_valid;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [PIXEL_W-1:0]     csr_data;

   int unsigned            mismatch_count;
   int unsigned            bgra_outstanding;

   // idling switches and the long-hold hand-off to the result side
   bit                     req_idling;
   bit                     rsp_idling;
   bit                     rsp_hold_request;
   // alpha mask as last written, used to build images with no alpha at all
   logic [PIXEL_W-1:0]     alpha_mask_shadow;

   always #(CLK_HALF) clock = ~clock;

   bitfield_pixel_to_bgra8_unit i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   bgra8_result_checker u_bgra_check (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .rsp_tuser   (rsp_tuser),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .error_count (mismatch_count),
      .outstanding (bgra_outstanding)
   );

   // hold request valid low and wait until every result has been taken
   task automatic wait_for_results();
      req_tvalid <= 1'b0;
      while (bgra_outstanding != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // register writes only ever happen with the block drained
   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx, input logic [PIXEL_W-1:0] value);
      wait_for_results();
      if (idx == CSR_ALPHA_MASK) begin
         alpha_mask_shadow = value;
      end
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   // entered at a falling edge; leaves valid high so back-to-back requests need no drop
   task automatic send_pixel(input logic [PIXEL_W-1:0] word, input logic last);
      int unsigned bursts;
      if (req_idling && $urandom_range(0, 3) == 0) begin
         // chained bursts so the gap can end anywhere in the block's pass over a pixel
         req_tvalid <= 1'b0;
         bursts = $urandom_range(1, 4);
         repeat (bursts) repeat ($urandom_range(1, 15)) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= word;
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   function automatic logic [PIXEL_W-1:0] random_run_mask();
      int unsigned width;
      int unsigned lsb;
      width = $urandom_range(1, PIXEL_W);
      lsb = $urandom_range(0, PIXEL_W - width);
      return PIXEL_W'(((64'd1 << width) - 64'd1) << lsb);
   endfunction

   // masks in red, green, blue, alpha order
   task automatic program_masks(input mask_style_type style);
      logic [PIXEL_W-1:0] m [4];
      case (style)
         MS_DEFAULT: m = '{RED_MASK_RST, GREEN_MASK_RST, BLUE_MASK_RST, ALPHA_MASK_RST};
         MS_565:     m = '{32'h0000_F800, 32'h0000_07E0, 32'h0000_001F, 32'h0000_0000};
         MS_555:     m = '{32'h0000_7C00, 32'h0000_03E0, 32'h0000_001F, 32'h0000_8000};
         MS_2101010: m = '{32'h3FF0_0000, 32'h000F_FC00, 32'h0000_03FF, 32'hC000_0000};
         MS_RUNS:    foreach (m[i]) m[i] = random_run_mask();
         MS_RANDOM:  foreach (m[i]) m[i] = $urandom;
         MS_EMPTY:   m = '{default: '0};
         default:    m = '{default: '1};
      endcase
      write_reg(CSR_RED_MASK, m[0]);
      write_reg(CSR_GREEN_MASK, m[1]);
      write_reg(CSR_BLUE_MASK, m[2]);
      write_reg(CSR_ALPHA_MASK, m[3]);
   endtask

   // result side: random ready bursts, plus one long hold on request of the stimulus
   initial begin : result_acceptor
      int unsigned span;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (rsp_hold_request) begin
            rsp_hold_request = 1'b0;
            rsp_tready <= 1'b0;
            span = LONG_HOLD_CYCLES;
         end else if (rsp_idling && $urandom_range(0, 3) == 0) begin
            rsp_tready <= 1'b0;
            span = $urandom_range(1, 15);
         end else begin
            rsp_tready <= 1'b1;
            span = rsp_idling ? $urandom_range(1, 40) : 1;
         end
         repeat (span - 1) @(negedge clock);
      end
   end

   initial begin : stimulus
      int unsigned        pixels_left;
      bit                 clear_alpha;
      logic [PIXEL_W-1:0] word;
      logic [PIXEL_W-1:0] noise;
      logic               last;

      // every input known from time zero
      reset             = 1'b1;
      req_tvalid        = 1'b0;
      req_tdata         = '0;
      req_tlast         = 1'b0;
      csr_valid         = 1'b0;
      csr_index         = CSR_RED_MASK;
      csr_data          = '0;
      req_idling        = 1'b1;
      rsp_idling        = 1'b1;
      rsp_hold_request  = 1'b0;
      alpha_mask_shadow = ALPHA_MASK_RST;
      pixels_left       = 0;
      clear_alpha       = 1'b0;

      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // ---- directed part, reset config: 8888 masks, 32-bit pixels ----
      // all-zero pixel, then an image whose alpha never goes nonzero
      send_pixel(32'h0000_0000, 1'b0);
      send_pixel(32'h00FF_FFFF, 1'b1);
      // full-scale pixel; alpha seen so the image end stays transparent-aware
      send_pixel(32'hFFFF_FFFF, 1'b0);
      send_pixel(32'h0100_0000, 1'b1);
      send_pixel(32'h80FF_00FF, 1'b1);

      // zero alpha mask: alpha is the raw top byte
      write_reg(CSR_ALPHA_MASK, 32'h0000_0000);
      send_pixel(32'hAB12_3456, 1'b0);
      send_pixel(32'h00AB_CDEF, 1'b1);
      send_pixel(32'h00FE_DCBA, 1'b1);

      // mask extremes: full width, single top bit, empty, and a mask with gaps
      write_reg(CSR_RED_MASK, 32'hFFFF_FFFF);
      write_reg(CSR_GREEN_MASK, 32'h8000_0000);
      write_reg(CSR_BLUE_MASK, 32'h0000_0000);
      write_reg(CSR_ALPHA_MASK, 32'h0F0F_0F0F);
      send_pixel(32'hFFFF_FFFF, 1'b0);
      send_pixel(32'h7FFF_FFFE, 1'b0);
      send_pixel(32'h1234_5678, 1'b1);

      // 24-bit byte copy; only bit 0 of the mode write counts, top pixel byte ignored
      write_reg(CSR_WIDE, 32'hFFFF_FFFE);
      write_reg(CSR_USE_BF, 32'h0000_0000);
      send_pixel(32'hFF12_3456, 1'b0);
      send_pixel(32'h00FF_FFFF, 1'b1);

      // 24-bit through 565 masks; image left open across the mode change
      write_reg(CSR_USE_BF, 32'h0000_0001);
      write_reg(CSR_RED_MASK, 32'h0000_F800);
      write_reg(CSR_GREEN_MASK, 32'h0000_07E0);
      write_reg(CSR_BLUE_MASK, 32'h0000_001F);
      send_pixel(32'hFF00_FFFF, 1'b0);
      send_pixel(32'h0000_1234, 1'b0);

      // back to 32-bit 8888; 24-bit pixels must not have touched the alpha history
      write_reg(CSR_RED_MASK, RED_MASK_RST);
      write_reg(CSR_GREEN_MASK, GREEN_MASK_RST);
      write_reg(CSR_BLUE_MASK, BLUE_MASK_RST);
      write_reg(CSR_ALPHA_MASK, ALPHA_MASK_RST);
      write_reg(CSR_WIDE, 32'h0000_0001);
      send_pixel(32'h00AB_CDEF, 1'b1);

      // alpha seen in 32-bit mode, a 24-bit pixel in between, then a bare last pixel
      send_pixel(32'hFF00_0000, 1'b0);
      write_reg(CSR_WIDE, 32'h0000_0000);
      send_pixel(32'h0000_0000, 1'b0);
      write_reg(CSR_WIDE, 32'h0000_0001);
      send_pixel(32'h0000_0000, 1'b1);

      // transparent 32-bit start, image closed by a 24-bit last pixel
      send_pixel(32'h0012_3456, 1'b0);
      write_reg(CSR_WIDE, 32'h0000_0000);
      send_pixel(32'h0065_4321, 1'b1);

      // writes past the register map leave every setting alone
      write_reg(CSR_WIDE, 32'h0000_0001);
      write_reg(CSR_SPARE_6, 32'hFFFF_FFFF);
      write_reg(CSR_SPARE_7, 32'h0000_0000);
      send_pixel(32'h0000_0000, 1'b1);

      // ---- random part: one register setting per phase, images of random length ----
      for (int unsigned phase = 0; phase < RANDOM_PHASES; phase++) begin
         // last phase runs flat out on both sides
         if (phase == RANDOM_PHASES - 1) begin
            req_idling = 1'b0;
            rsp_idling = 1'b0;
         end
         if (phase == 0) begin
            program_masks(MS_FULL);
         end else if (phase == 1) begin
            program_masks(MS_EMPTY);
         end else begin
            program_masks(mask_style_type'($urandom_range(0, MS_FULL)));
         end
         noise = $urandom;
         write_reg(CSR_WIDE, {noise[31:1], (phase == 1) ? 1'b0 : 1'($urandom_range(0, 1))});
         noise = $urandom;
         write_reg(CSR_USE_BF, {noise[31:1], 1'($urandom_range(0, 1))});
         if ($urandom_range(0, 2) == 0) begin
            write_reg($urandom_range(0, 1) ? CSR_SPARE_6 : CSR_SPARE_7, $urandom);
         end

         // images may run on into the next phase, which changes the mode mid-image
         for (int unsigned n = 0; n < PHASE_PIXELS; n++) begin
            if (pixels_left == 0) begin
               pixels_left = $urandom_range(1, 16);
               clear_alpha = ($urandom_range(0, 2) == 0);
            end
            // long result-side hold while requests keep coming
            if (phase == HOLD_PHASE && n == 10) begin
               rsp_hold_request = 1'b1;
            end
            // sender stops until the block has handed back everything
            if (phase == PAUSE_PHASE && n == PHASE_PIXELS / 2) begin
               wait_for_results();
            end
            word = $urandom;
            if (clear_alpha) begin
               if (alpha_mask_shadow == '0) begin
                  word[31:24] = 8'h00;
               end else begin
                  word = word & ~alpha_mask_shadow;
               end
            end
            pixels_left--;
            last = (pixels_left == 0);
            // now and then a stray or missing end-of-image marker
            if ($urandom_range(0, 29) == 0) begin
               last = ~last;
            end
            send_pixel(word, last);
         end
      end

      wait_for_results();
      repeat (TAIL_CYCLES) @(negedge clock);
      if (mismatch_count == 0 && bgra_outstanding == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   // hard stop well past the slowest legal run
   initial begin : watchdog
      #(6_000_000);
      $display("FAIL");
      $finish;
   end

endmodule
